### src/smrm_pkg.sv
// ----------------------------------------------------------------------------
// SPI memory read master package
// Shared widths, register indexes and sequence step codes.
// ----------------------------------------------------------------------------
package smrm_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int ADDR_WIDTH  = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_COUNT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_OPCODE   = 2'd3;

   typedef logic [1:0] step_type;

   localparam step_type STEP_IDLE   = 2'd0;
   localparam step_type STEP_HEADER = 2'd1;
   localparam step_type STEP_DATA   = 2'd2;

endpackage

### src/smrm_if.sv
// ----------------------------------------------------------------------------
// SPI memory read master channels
// Valid/ready channels for tick beats, pin result beats and register writes.
// ----------------------------------------------------------------------------
interface smrm_req_if;
   logic valid;
   logic ready;
   logic func;
   logic miso_level;

   modport source (output valid, output func, output miso_level, input ready);
   modport sink   (input valid, input func, input miso_level, output ready);
endinterface

interface smrm_rsp_if;
   logic       valid;
   logic       ready;
   logic       chip_select_n;
   logic       serial_clock;
   logic       serial_out;
   logic [7:0] read_byte;
   logic       byte_valid;
   logic       last_byte;
   logic       busy_res;

   modport source (output valid, output chip_select_n, output serial_clock,
                   output serial_out, output read_byte, output byte_valid,
                   output last_byte, output busy_res, input ready);
   modport sink   (input valid, input chip_select_n, input serial_clock,
                   input serial_out, input read_byte, input byte_valid,
                   input last_byte, input busy_res, output ready);
endinterface

interface smrm_csr_if import smrm_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/spi_memory_read_master.sv
// ----------------------------------------------------------------------------
// SPI memory read master
// Mode 0 read transaction: opcode, 2 or 3 address bytes, then data bytes.
// ----------------------------------------------------------------------------
//  channel   | dir | beat
//  req_chan  | in  | func (tick / start), miso_level
//  rsp_chan  | out | pin levels, read_byte, byte_valid, last_byte, busy_res
//  csr_chan  | in  | register index, write data (always ready)
//
// One beat per clock: each request beat updates the sequencer and loads the
// result register in the same cycle. The result register is the only stage;
// a new beat is taken whenever it is empty or being drained. Synchronous
// reset returns to idle, registers to defaults; pin outputs are not reset.
// ----------------------------------------------------------------------------
module spi_memory_read_master import smrm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   smrm_req_if.sink     req_chan,
   smrm_rsp_if.source   rsp_chan,
   smrm_csr_if.sink     csr_chan
);

   logic                   address_mode_ff;
   logic [ADDR_WIDTH-1:0]  start_address_ff;
   logic [COUNT_WIDTH-1:0] byte_count_ff;
   logic [7:0]             read_opcode_ff;

   step_type               step_ff, step_in;
   logic                   phase_ff, phase_in;
   logic [2:0]             bit_ff, bit_in;
   logic [1:0]             hdr_ff, hdr_in;
   logic [7:0]             shift_ff, shift_in;
   logic [COUNT_WIDTH-1:0] left_ff, left_in;

   logic                   rsp_valid_ff;
   logic                   cs_n_ff, sclk_ff, mosi_ff, bvalid_ff, last_ff, busy_ff;
   logic [7:0]             rbyte_ff;

   logic                   busy, busy_next, emit, last;
   logic [7:0]             done_byte, addr_byte;
   logic [2:0]             hdr_next, hdr_total, byte_shift;
   logic                   req_fire;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_mode_ff  <= 1'b1;
         start_address_ff <= '0;
         byte_count_ff    <= '0;
         read_opcode_ff   <= 8'd3;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_ADDRESS_MODE:  address_mode_ff  <= csr_chan.data[0];
            CSR_START_ADDRESS: start_address_ff <= csr_chan.data[ADDR_WIDTH-1:0];
            CSR_BYTE_COUNT:    byte_count_ff    <= csr_chan.data[COUNT_WIDTH-1:0];
            CSR_READ_OPCODE:   read_opcode_ff   <= csr_chan.data[7:0];
            default: ;
         endcase
      end
   end

   assign hdr_next   = {1'b0, hdr_ff} + 3'd1;
   assign hdr_total  = address_mode_ff ? 3'd4 : 3'd3;
   assign byte_shift = hdr_total - 3'd1 - hdr_next;

   always_comb begin
      case (byte_shift)
         3'd0:    addr_byte = start_address_ff[7:0];
         3'd1:    addr_byte = start_address_ff[15:8];
         3'd2:    addr_byte = start_address_ff[23:16];
         default: addr_byte = 8'd0;
      endcase
   end

   always_comb begin
      step_in   = step_ff;
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      hdr_in    = hdr_ff;
      shift_in  = shift_ff;
      left_in   = left_ff;
      emit      = 1'b0;
      last      = 1'b0;
      done_byte = 8'd0;
      busy      = (step_ff == STEP_HEADER) || (step_ff == STEP_DATA);
      if (!busy) begin
         step_in = STEP_IDLE;
         if (req_chan.func) begin
            step_in  = STEP_HEADER;
            phase_in = 1'b0;
            bit_in   = 3'd7;
            hdr_in   = 2'd0;
            shift_in = read_opcode_ff;
            left_in  = byte_count_ff;
         end
      end else if (!req_chan.func) begin
         if (!phase_ff) begin
            phase_in = 1'b1;
            if (step_ff == STEP_DATA) begin
               shift_in = shift_ff | (8'(req_chan.miso_level) << bit_ff);
               if (bit_ff == 3'd0) begin
                  emit      = 1'b1;
                  done_byte = shift_in;
                  if (left_ff != '0) begin
                     left_in = left_ff - COUNT_WIDTH'(1);
                  end
                  last = (left_in == '0);
               end
            end
         end else begin
            phase_in = 1'b0;
            if (step_ff == STEP_HEADER) begin
               if (bit_ff == 3'd0) begin
                  bit_in = 3'd7;
                  if (hdr_next >= hdr_total) begin
                     hdr_in   = 2'd0;
                     shift_in = 8'd0;
                     step_in  = (left_ff == '0) ? STEP_IDLE : STEP_DATA;
                  end else begin
                     hdr_in   = hdr_next[1:0];
                     shift_in = addr_byte;
                  end
               end else begin
                  bit_in = bit_ff - 3'd1;
               end
            end else begin
               if (bit_ff == 3'd0) begin
                  bit_in   = 3'd7;
                  shift_in = 8'd0;
                  if (left_ff == '0) begin
                     step_in = STEP_IDLE;
                  end
               end else begin
                  bit_in = bit_ff - 3'd1;
               end
            end
         end
      end
      busy_next = (step_in == STEP_HEADER) || (step_in == STEP_DATA);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_IDLE;
         phase_ff <= 1'b0;
         bit_ff   <= 3'd7;
         hdr_ff   <= 2'd0;
         shift_ff <= 8'd0;
         left_ff  <= '0;
      end else if (req_fire) begin
         step_ff  <= step_in;
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         hdr_ff   <= hdr_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cs_n_ff   <= !busy_next;
         sclk_ff   <= busy_next && phase_in;
         mosi_ff   <= (step_in == STEP_HEADER) && shift_in[bit_in];
         rbyte_ff  <= done_byte;
         bvalid_ff <= emit;
         last_ff   <= emit && last;
         busy_ff   <= busy_next;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.chip_select_n = cs_n_ff;
   assign rsp_chan.serial_clock  = sclk_ff;
   assign rsp_chan.serial_out    = mosi_ff;
   assign rsp_chan.read_byte     = rbyte_ff;
   assign rsp_chan.byte_valid    = bvalid_ff;
   assign rsp_chan.last_byte     = last_ff;
   assign rsp_chan.busy_res      = busy_ff;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI memory read master testbench
// Drives start and half-period tick beats with random MISO levels through
// whole read transactions under several register settings, and checks every
// pin beat against a cycle model of the sequencer. Sender bursts and receiver
// stalls are random, with one long receiver hold-off to back up the input.
// ----------------------------------------------------------------------------
module testbench import smrm_pkg::*; ;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   typedef struct packed {
      logic       cs_n;
      logic       sclk;
      logic       sout;
      logic [7:0] rbyte;
      logic       bvalid;
      logic       last;
      logic       busy;
   } pin_beat_type;

   typedef struct packed {
      logic         func;
      logic         miso;
      logic         typed;
      pin_beat_type want;
   } dir_row_type;

   typedef enum int {RX_ALWAYS, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_type;

   localparam pin_beat_type IDLE_PINS  = '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam pin_beat_type START_PINS = '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1};

   logic clock;
   logic reset;

   smrm_req_if req_chan ();
   smrm_rsp_if rsp_chan ();
   smrm_csr_if csr_chan ();

   spi_memory_read_master dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // sequencer model state and registers
   logic        cfg_addr_mode;
   logic [23:0] cfg_start_addr;
   logic [23:0] cfg_byte_count;
   logic [7:0]  cfg_opcode;
   step_type    seq_step;
   logic        half;
   logic [2:0]  bit_pos;
   logic [1:0]  hdr_idx;
   logic [7:0]  shifter;
   logic [23:0] bytes_left;

   pin_beat_type expected_pins [$];
   int        mismatches   = 0;
   int        beats_sent   = 0;
   int        transactions = 0;
   int        csr_writes   = 0;
   int        bytes_read   = 0;
   int        lasts_seen   = 0;
   int        burst_left   = 0;
   int        stall_hold   = 0;

   dir_row_type dir_rows [24] = '{
      '{FUNC_TICK,  1'b0, 1'b1, IDLE_PINS},  '{FUNC_TICK,  1'b1, 1'b1, IDLE_PINS},
      '{FUNC_START, 1'b0, 1'b1, START_PINS}, '{FUNC_START, 1'b1, 1'b1, START_PINS},
      '{FUNC_TICK,  1'b1, 1'b0, '0}, '{FUNC_TICK,  1'b0, 1'b0, '0},
      '{FUNC_TICK,  1'b0, 1'b0, '0}, '{FUNC_TICK,  1'b1, 1'b0, '0},
      '{FUNC_START, 1'b0, 1'b0, '0}, '{FUNC_TICK,  1'b1, 1'b0, '0},
      '{FUNC_TICK,  1'b1, 1'b0, '0}, '{FUNC_START, 1'b1, 1'b0, '0},
      '{FUNC_TICK,  1'b0, 1'b0, '0}, '{FUNC_TICK,  1'b1, 1'b0, '0},
      '{FUNC_TICK,  1'b0, 1'b0, '0}, '{FUNC_TICK,  1'b1, 1'b0, '0},
      '{FUNC_TICK,  1'b1, 1'b0, '0}, '{FUNC_TICK,  1'b0, 1'b0, '0},
      '{FUNC_TICK,  1'b1, 1'b0, '0}, '{FUNC_TICK,  1'b1, 1'b0, '0},
      '{FUNC_TICK,  1'b0, 1'b0, '0}, '{FUNC_TICK,  1'b0, 1'b0, '0},
      '{FUNC_TICK,  1'b1, 1'b0, '0}, '{FUNC_TICK,  1'b0, 1'b0, '0}
   };

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void reset_sequencer();
      cfg_addr_mode  = 1'b1;
      cfg_start_addr = '0;
      cfg_byte_count = '0;
      cfg_opcode     = 8'h03;
      seq_step       = STEP_IDLE;
      half           = 1'b0;
      bit_pos        = 3'd7;
      hdr_idx        = '0;
      shifter        = '0;
      bytes_left     = '0;
   endfunction

   function automatic logic seq_active();
      return seq_step == STEP_HEADER || seq_step == STEP_DATA;
   endfunction

   function automatic pin_beat_type advance_sequencer(logic func, logic miso);
      logic         emit;
      logic         is_last;
      logic [7:0]   done_byte;
      int           next_idx;
      int           hdr_total;
      pin_beat_type pins;
      emit      = 1'b0;
      is_last   = 1'b0;
      done_byte = '0;
      if (!seq_active()) begin
         seq_step = STEP_IDLE;
         if (func == FUNC_START) begin
            seq_step   = STEP_HEADER;
            half       = 1'b0;
            bit_pos    = 3'd7;
            hdr_idx    = '0;
            shifter    = cfg_opcode;
            bytes_left = cfg_byte_count;
         end
      end else if (func == FUNC_TICK) begin
         if (!half) begin
            half = 1'b1;
            if (seq_step == STEP_DATA) begin
               shifter[bit_pos] = shifter[bit_pos] | miso;
               if (bit_pos == 3'd0) begin
                  emit      = 1'b1;
                  done_byte = shifter;
                  if (bytes_left != 0)
                     bytes_left = bytes_left - 24'd1;
                  is_last = (bytes_left == 0);
               end
            end
         end else begin
            half = 1'b0;
            if (bit_pos != 3'd0) begin
               bit_pos = bit_pos - 3'd1;
            end else if (seq_step == STEP_HEADER) begin
               next_idx  = int'(hdr_idx) + 1;
               hdr_total = cfg_addr_mode ? 4 : 3;
               bit_pos   = 3'd7;
               if (next_idx >= hdr_total) begin
                  hdr_idx  = '0;
                  shifter  = '0;
                  seq_step = (bytes_left == 0) ? STEP_IDLE : STEP_DATA;
               end else begin
                  hdr_idx = next_idx[1:0];
                  shifter = 8'(cfg_start_addr >> (8 * (hdr_total - 1 - next_idx)));
               end
            end else begin
               bit_pos = 3'd7;
               shifter = '0;
               if (bytes_left == 0)
                  seq_step = STEP_IDLE;
            end
         end
      end
      pins.busy   = seq_active();
      pins.cs_n   = !pins.busy;
      pins.sclk   = pins.busy & half;
      pins.sout   = (seq_step == STEP_HEADER) ? shifter[bit_pos] : 1'b0;
      pins.rbyte  = done_byte;
      pins.bvalid = emit;
      pins.last   = is_last;
      return pins;
   endfunction

   task automatic send_beat(logic func, logic miso, logic typed = 1'b0,
                            pin_beat_type want = '0);
      pin_beat_type predicted;
      int           gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.func       <= func;
      req_chan.miso_level <= miso;
      @(posedge clock);
      while (req_chan.ready !== 1'b1)
         @(posedge clock);
      predicted = advance_sequencer(func, miso);
      expected_pins.push_back(typed ? want : predicted);
      beats_sent++;
      burst_left--;
   endtask

   task automatic finish_transaction();
      logic func;
      while (seq_active()) begin
         func = ($urandom_range(0, 39) == 0) ? FUNC_START : FUNC_TICK;
         send_beat(func, 1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(0, 3))
         send_beat(FUNC_TICK, 1'($urandom_range(0, 1)));
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_pins.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (csr_chan.ready !== 1'b1)
         @(posedge clock);
      case (idx)
         CSR_ADDRESS_MODE:  cfg_addr_mode  = value[0];
         CSR_START_ADDRESS: cfg_start_addr = value[23:0];
         CSR_BYTE_COUNT:    cfg_byte_count = value[23:0];
         CSR_READ_OPCODE:   cfg_opcode     = value[7:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic write_setting(logic mode, logic [23:0] addr, logic [23:0] count,
                                logic [7:0] opcode);
      write_reg(CSR_ADDRESS_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_START_ADDRESS, CSR_DATA_W'(addr));
      write_reg(CSR_BYTE_COUNT, CSR_DATA_W'(count));
      write_reg(CSR_READ_OPCODE, CSR_DATA_W'(opcode));
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin : receiver
      rx_mode_type mode;
      int          span;
      mode = RX_ALWAYS;
      span = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_hold--;
         end else begin
            if (span == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               span = $urandom_range(16, 128);
            end
            span--;
            case (mode)
               RX_ALWAYS:   rsp_chan.ready <= 1'b1;
               RX_LIGHT:    rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               RX_PERIODIC: rsp_chan.ready <= (span[1:0] != 2'd0);
               default:     rsp_chan.ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      pin_beat_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_pins.size() == 0) begin
            $error("pin beat with nothing expected");
            mismatches++;
         end else begin
            want = expected_pins.pop_front();
            check_field("chip_select_n", 8'(want.cs_n), 8'(rsp_chan.chip_select_n));
            check_field("serial_clock", 8'(want.sclk), 8'(rsp_chan.serial_clock));
            check_field("serial_out", 8'(want.sout), 8'(rsp_chan.serial_out));
            check_field("read_byte", want.rbyte, rsp_chan.read_byte);
            check_field("byte_valid", 8'(want.bvalid), 8'(rsp_chan.byte_valid));
            check_field("last_byte", 8'(want.last), 8'(rsp_chan.last_byte));
            check_field("busy_res", 8'(want.busy), 8'(rsp_chan.busy_res));
            bytes_read += want.bvalid;
            lasts_seen += want.last;
         end
      end
   end

   initial begin : stimulus
      int phase_start;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.func       = FUNC_TICK;
      req_chan.miso_level = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = CSR_ADDRESS_MODE;
      csr_chan.data       = '0;
      reset_sequencer();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_beat(dir_rows[i].func, dir_rows[i].miso, dir_rows[i].typed, dir_rows[i].want);
      finish_transaction();
      transactions++;

      for (int p = 0; p < 12; p++) begin
         drain();
         case (p)
            0:       write_setting(1'b0, 24'hFFFFFF, 24'd1, 8'hFF);
            1:       write_setting(1'b1, 24'hFFFFFF, 24'd3, 8'h00);
            2:       write_setting(1'b0, 24'h000000, 24'd0, 8'h03);
            default: write_setting(1'($urandom_range(0, 1)), 24'($urandom_range(0, 24'hFFFFFF)),
                                   24'($urandom_range(0, 4)), 8'($urandom_range(0, 255)));
         endcase
         if (p == 1)
            stall_hold = 300;
         phase_start = beats_sent;
         while (beats_sent - phase_start < 160) begin
            send_beat(FUNC_START, 1'($urandom_range(0, 1)));
            finish_transaction();
            transactions++;
         end
      end

      // huge count: the transaction stays open for the rest of the run
      drain();
      write_reg(CSR_BYTE_COUNT, CSR_DATA_W'(24'hFFFFFF));
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      send_beat(FUNC_START, 1'b0);
      transactions++;
      repeat (200)
         send_beat(($urandom_range(0, 49) == 0) ? FUNC_START : FUNC_TICK,
                   1'($urandom_range(0, 1)));
      drain();
      repeat (8) @(posedge clock);

      $display("Ran %0d request beats over %0d transactions with %0d register writes.",
               beats_sent, transactions, csr_writes);
      $display("Read %0d data bytes, %0d of them flagged last.", bytes_read, lasts_seen);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
